// ===== rtl/neighbor_mean_filter_3x3_core_assert.svh =====
// Assertion macros for the neighbor mean filter core.
`ifndef NEIGHBOR_MEAN_FILTER_3X3_CORE_ASSERT_SVH
`define NEIGHBOR_MEAN_FILTER_3X3_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off during reset.
`define NMF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nmf assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define NMF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nmf assertion failed");

`else

`define NMF_ASSERT_IMP(lbl, ante, cons)
`define NMF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/nmf_pkg.sv =====
package nmf_pkg;

	localparam int MAX_SIZE_DEF = 1024;

	localparam int SIZE_W = 11;
	localparam int PIX_W  = 8;
	localparam int POS_W  = 10;
	localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = 11'd10;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic REG_IMAGE_SIZE = 1'b0;

	// row store
	localparam int ROW_SLOTS = 3;
	localparam int SLOT_W    = 2;

	// mean arithmetic: sum of up to eight pixels, reciprocals for 3 and 5
	localparam int SUM_W  = 11;
	localparam int RCP_W  = 12;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP3 = 12'd683;
	localparam int SHIFT3 = 11;
	localparam logic [RCP_W-1:0] RECIP5 = 12'd3277;
	localparam int SHIFT5 = 14;
	localparam int SHIFT8 = 3;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PW    = $clog2(RES_DEPTH);

	typedef struct packed {
		logic             req_type;
		logic [PIX_W-1:0] pixel_value;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] mean_value;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             frame_end;
		logic             run_last;
	} res_t;

	// one window column: rows above, at and below the center row
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col_t;

	typedef struct packed {
		logic has_left;
		logic has_right;
		logic has_top;
		logic has_bot;
	} win_flags_t;

endpackage

// ===== rtl/neighbor_mean_filter_3x3_core.sv =====
// channel | role   | handshake             | payload
// pix     | input  | pix_valid / pix_stall | pix (req_type, pixel_value)
// res     | output | res_valid / res_stall | res (mean, row, col, frame_end, run_last)
// cfg     | APB    | psel/penable/pready   | image_size at byte address 0
//
// One transaction per clock on pix while pix_stall is low; results enter the queue from the stage 1 register.
// A pixel at the last column of any row but the first yields two results, so a row end can add a stall.
// pix_stall rises while stage 1 holds a transaction and the four-entry result queue holds more than two results.
// Reset clears counters, queue and stage valid; the row store is not cleared.
// Writing image_size restarts the frame.
`include "neighbor_mean_filter_3x3_core_assert.svh"

module neighbor_mean_filter_3x3_core #(
	parameter int MAX_SIZE = nmf_pkg::MAX_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  nmf_pkg::pix_t                pix,
	output logic                         res_valid,
	input  logic                         res_stall,
	output nmf_pkg::res_t                res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nmf_pkg::CFG_AW-1:0]   paddr,
	input  logic [nmf_pkg::CFG_DW-1:0]   pwdata,
	output logic [nmf_pkg::CFG_DW-1:0]   prdata,
	output logic                         pready
);
	import nmf_pkg::*;

	localparam int CW = $clog2(MAX_SIZE);
	localparam int NW = $clog2(MAX_SIZE + 1);

	function automatic logic [SLOT_W-1:0] inc3(input logic [SLOT_W-1:0] s);
		inc3 = (s == SLOT_W'(ROW_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	// configuration
	logic [SIZE_W-1:0] image_size_q;
	logic              cfg_hit;
	logic              cfg_we;
	logic [NW-1:0]     eff_n;
	logic [CW-1:0]     last_pos;

	// input side position state
	logic [CW-1:0]     in_row_q;
	logic [CW-1:0]     in_col_q;
	logic [SLOT_W-1:0] rs_q;
	logic [SLOT_W-1:0] last_slot_q;
	logic              flush_act_q;
	logic [CW-1:0]     flush_pos_q;
	logic              pix_acc;
	logic              is_flush;

	// row store
	logic                             mem_we;
	logic                             mem_re;
	logic [CW-1:0]                    mem_raddr;
	logic [ROW_SLOTS-1:0][PIX_W-1:0]  mem_rdata;

	// stage 1
	logic              s1_valid_q;
	logic              s1_adv;
	logic              flush_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic              emit0_s1;
	logic              emit1_s1;
	logic              shift_s1;
	logic              first_s1;
	logic              fend_s1;
	logic              head_cap_s1;
	win_flags_t        flags_s1;
	logic [CW-1:0]     row_s1;
	logic [CW-1:0]     col_s1;
	logic [SLOT_W-1:0] top_sel_s1;
	logic [SLOT_W-1:0] mid_sel_s1;

	// window
	col_t       w1_q;
	col_t       w2_q;
	col_t       head_q;
	col_t       cur_col;
	col_t       center_eff;
	win_flags_t flags_b;
	logic [PIX_W-1:0] mean0;
	logic [PIX_W-1:0] mean1;
	res_t       r0;
	res_t       r1;

	// result queue
	res_t              fq [RES_DEPTH];
	logic [RES_PW-1:0] wr_ptr_q;
	logic [RES_PW-1:0] rd_ptr_q;
	logic [RES_PW:0]   fifo_cnt_q;
	logic              pop;
	logic [RES_PW:0]   push_n;

	// ---------------------------------------------------------------- config
	assign cfg_hit = (paddr[CFG_AW-1:2] == REG_IMAGE_SIZE);
	assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
	assign pready  = 1'b1;
	assign prdata  = cfg_hit ? CFG_DW'(image_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= IMAGE_SIZE_RST;
		end else if (cfg_we) begin
			image_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		if (image_size_q < SIZE_W'(2)) begin
			eff_n = NW'(2);
		end else if (32'(image_size_q) > MAX_SIZE) begin
			eff_n = NW'(MAX_SIZE);
		end else begin
			eff_n = NW'(image_size_q);
		end
	end

	assign last_pos = CW'(eff_n - NW'(1));

	// ---------------------------------------------------------------- input
	assign pix_stall = s1_valid_q && !s1_adv;
	assign pix_acc   = pix_valid && !pix_stall;
	assign is_flush  = pix.req_type;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			rs_q        <= '0;
			last_slot_q <= '0;
			flush_act_q <= 1'b0;
			flush_pos_q <= '0;
		end else if (cfg_we) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			rs_q        <= '0;
			flush_act_q <= 1'b0;
		end else if (pix_acc) begin
			if (is_flush) begin
				if (flush_act_q) begin
					if (flush_pos_q == last_pos) begin
						flush_act_q <= 1'b0;
					end else begin
						flush_pos_q <= flush_pos_q + 1'b1;
					end
				end
			end else begin
				flush_act_q <= 1'b0;
				if (in_col_q == last_pos) begin
					in_col_q <= '0;
					if (in_row_q == last_pos) begin
						in_row_q    <= '0;
						rs_q        <= '0;
						last_slot_q <= rs_q;
						flush_act_q <= 1'b1;
						flush_pos_q <= '0;
					end else begin
						in_row_q <= in_row_q + 1'b1;
						rs_q     <= inc3(rs_q);
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
		end
	end

	// flushes read one column ahead; the first drain column comes from head_q
	assign mem_we    = pix_acc && !is_flush;
	assign mem_re    = pix_acc;
	assign mem_raddr = is_flush ? CW'(flush_pos_q + 1'b1) : in_col_q;

	nmf_rows #(
		.DEPTH (MAX_SIZE),
		.AW    (CW)
	) u_rows (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_slot (rs_q),
		.wr_addr (in_col_q),
		.wr_data (pix.pixel_value),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// ---------------------------------------------------------------- stage 1
	assign s1_adv = s1_valid_q && (fifo_cnt_q <= (RES_PW + 1)'(RES_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= pix_acc || (s1_valid_q && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			flush_s1    <= is_flush;
			pixel_s1    <= pix.pixel_value;
			head_cap_s1 <= !is_flush && (in_row_q == last_pos) && (in_col_q == '0);
			if (is_flush) begin
				emit0_s1           <= flush_act_q;
				emit1_s1           <= 1'b0;
				shift_s1           <= flush_act_q;
				first_s1           <= (flush_pos_q == '0);
				fend_s1            <= (flush_pos_q == last_pos);
				flags_s1.has_left  <= (flush_pos_q != '0);
				flags_s1.has_right <= (flush_pos_q != last_pos);
				flags_s1.has_top   <= 1'b1;
				flags_s1.has_bot   <= 1'b0;
				row_s1             <= last_pos;
				col_s1             <= flush_pos_q;
				top_sel_s1         <= inc3(inc3(last_slot_q));
				mid_sel_s1         <= last_slot_q;
			end else begin
				emit0_s1           <= (in_row_q != '0) && (in_col_q != '0);
				emit1_s1           <= (in_row_q != '0) && (in_col_q == last_pos);
				shift_s1           <= 1'b1;
				first_s1           <= 1'b0;
				fend_s1            <= 1'b0;
				flags_s1.has_left  <= (in_col_q > CW'(1));
				flags_s1.has_right <= 1'b1;
				flags_s1.has_top   <= (in_row_q > CW'(1));
				flags_s1.has_bot   <= 1'b1;
				row_s1             <= in_row_q - 1'b1;
				col_s1             <= in_col_q - 1'b1;
				top_sel_s1         <= inc3(rs_q);
				mid_sel_s1         <= inc3(inc3(rs_q));
			end
		end
	end

	assign cur_col.top = mem_rdata[top_sel_s1];
	assign cur_col.mid = mem_rdata[mid_sel_s1];
	assign cur_col.bot = pixel_s1;
	assign center_eff  = (flush_s1 && first_s1) ? head_q : w2_q;

	assign flags_b.has_left  = 1'b1;
	assign flags_b.has_right = 1'b0;
	assign flags_b.has_top   = flags_s1.has_top;
	assign flags_b.has_bot   = 1'b1;

	nmf_mean u_mean0 (
		.left_col   (w1_q),
		.center_col (center_eff),
		.right_col  (cur_col),
		.flags      (flags_s1),
		.mean       (mean0)
	);

	// second result of a row end: center is the last column
	nmf_mean u_mean1 (
		.left_col   (w2_q),
		.center_col (cur_col),
		.right_col  (cur_col),
		.flags      (flags_b),
		.mean       (mean1)
	);

	assign r0.mean_value = mean0;
	assign r0.out_row    = POS_W'(row_s1);
	assign r0.out_col    = POS_W'(col_s1);
	assign r0.frame_end  = fend_s1;
	assign r0.run_last   = !emit1_s1;

	assign r1.mean_value = mean1;
	assign r1.out_row    = POS_W'(row_s1);
	assign r1.out_col    = POS_W'(last_pos);
	assign r1.frame_end  = 1'b0;
	assign r1.run_last   = 1'b1;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (shift_s1) begin
				w1_q <= center_eff;
				w2_q <= cur_col;
			end
			if (head_cap_s1) begin
				head_q.top <= cur_col.mid;
				head_q.mid <= cur_col.bot;
				head_q.bot <= cur_col.bot;
			end
		end
	end

	// ---------------------------------------------------------------- result queue
	assign res_valid = (fifo_cnt_q != '0);
	assign res       = fq[rd_ptr_q];
	assign pop       = res_valid && !res_stall;
	assign push_n    = s1_adv ? ((RES_PW + 1)'(emit0_s1) + (RES_PW + 1)'(emit1_s1)) : '0;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (emit0_s1) begin
				fq[wr_ptr_q] <= r0;
			end
			if (emit1_s1) begin
				fq[wr_ptr_q + 1'b1] <= r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wr_ptr_q   <= wr_ptr_q + RES_PW'(push_n);
			rd_ptr_q   <= rd_ptr_q + RES_PW'(pop);
			fifo_cnt_q <= fifo_cnt_q + push_n - (RES_PW + 1)'(pop);
		end
	end

	// ---------------------------------------------------------------- checks
	`NMF_ASSERT_IMP(a_col_in_frame, 1'b1, in_col_q <= last_pos)
	`NMF_ASSERT_IMP(a_row_in_frame, 1'b1, in_row_q <= last_pos)
	`NMF_ASSERT_IMP(a_drain_in_frame, flush_act_q, flush_pos_q <= last_pos)
	`NMF_ASSERT_IMP(a_row_end_pair, s1_valid_q && emit1_s1, emit0_s1 && !flush_s1)
	`NMF_ASSERT_NXT(a_queue_bound, s1_adv, fifo_cnt_q <= (RES_PW + 1)'(RES_DEPTH))

endmodule

// ===== rtl/nmf_rows.sv =====
module nmf_rows #(
	parameter int DEPTH = nmf_pkg::MAX_SIZE_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [nmf_pkg::SLOT_W-1:0]                    wr_slot,
	input  logic [AW-1:0]                                 wr_addr,
	input  logic [nmf_pkg::PIX_W-1:0]                     wr_data,
	input  logic                                          rd_en,
	input  logic [AW-1:0]                                 rd_addr,
	output logic [nmf_pkg::ROW_SLOTS-1:0][nmf_pkg::PIX_W-1:0] rd_data
);
	import nmf_pkg::*;

	for (genvar s = 0; s < ROW_SLOTS; s++) begin : g_slot
		logic [PIX_W-1:0] mem [DEPTH];
		logic [PIX_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (wr_en && wr_slot == SLOT_W'(s)) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_q <= mem[rd_addr];
			end
		end

		assign rd_data[s] = rd_q;
	end

endmodule

// ===== rtl/nmf_mean.sv =====
module nmf_mean (
	input  nmf_pkg::col_t             left_col,
	input  nmf_pkg::col_t             center_col,
	input  nmf_pkg::col_t             right_col,
	input  nmf_pkg::win_flags_t       flags,
	output logic [nmf_pkg::PIX_W-1:0] mean
);
	import nmf_pkg::*;

	logic [SUM_W-1:0]  sum;
	logic              wide3;
	logic              tall3;
	logic [RCP_W-1:0]  recip;
	logic [PROD_W-1:0] prod;

	always_comb begin
		sum = '0;
		if (flags.has_left) begin
			sum = sum + SUM_W'(left_col.mid);
		end
		if (flags.has_right) begin
			sum = sum + SUM_W'(right_col.mid);
		end
		if (flags.has_top) begin
			sum = sum + SUM_W'(center_col.top);
			if (flags.has_left) begin
				sum = sum + SUM_W'(left_col.top);
			end
			if (flags.has_right) begin
				sum = sum + SUM_W'(right_col.top);
			end
		end
		if (flags.has_bot) begin
			sum = sum + SUM_W'(center_col.bot);
			if (flags.has_left) begin
				sum = sum + SUM_W'(left_col.bot);
			end
			if (flags.has_right) begin
				sum = sum + SUM_W'(right_col.bot);
			end
		end
	end

	assign wide3 = flags.has_left & flags.has_right;
	assign tall3 = flags.has_top & flags.has_bot;
	assign recip = (wide3 || tall3) ? RECIP5 : RECIP3;
	assign prod  = PROD_W'(sum) * PROD_W'(recip);

	// count is 8 (full window), 5 (edge) or 3 (corner)
	always_comb begin
		if (wide3 && tall3) begin
			mean = sum[SHIFT8 +: PIX_W];
		end else if (wide3 || tall3) begin
			mean = prod[SHIFT5 +: PIX_W];
		end else begin
			mean = prod[SHIFT3 +: PIX_W];
		end
	end

endmodule
